/* hdl/ppa_pkg.sv */
// Package for the physical page allocator: request and status codes,
// field widths, controller state and the command/status structs.
// No dependencies.
package ppa_pkg;

    localparam int ADDR_W    = 32;
    localparam int REQ_W     = 3;
    localparam int OWNER_W   = 5;
    localparam int STATUS_W  = 3;
    localparam int GRANT_W   = 21;
    localparam int CNT_OUT_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC  = 3'd0,
        REQ_ASSIGN = 3'd1,
        REQ_FREE   = 3'd2,
        REQ_SHARE  = 3'd3,
        REQ_QUERY  = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_RANGE      = 3'd2,
        ST_IN_USE     = 3'd3,
        ST_NONE_FREE  = 3'd4,
        ST_NOT_HELD   = 3'd5,
        ST_SATURATED  = 3'd6
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_SCAN   = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic req_load;
        logic rd_first;
        logic rd_page;
        logic rd_next;
        logic resp_load;
    } ppa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic cnt_zero;
        logic chk_last;
    } ppa_sts_t;

endpackage

/* hdl/physical_page_allocator.sv */
// Sequence: assign, free, share and query requests pass through the lookup and
// response states; alloc instead scans the page table from page 0 until it finds a
// free page or reaches the last page. The response state holds until the output is free.
// Flow: one request in flight; the next is accepted the cycle after the result
// is loaded; the page table scan sets alloc time.
// Reset: a clearing pass zeroes every page table entry; in_ready stays low.
module physical_page_allocator
#(
    parameter int NUM_PAGES  = 512,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ppa_pkg::REQ_W-1:0]             req_type,
    input  logic [ppa_pkg::ADDR_W-1:0]            page_address,
    input  logic signed [ppa_pkg::OWNER_W-1:0]    owner_id,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ppa_pkg::STATUS_W-1:0]          status,
    output logic [ppa_pkg::GRANT_W-1:0]           granted_address,
    output logic [ppa_pkg::CNT_OUT_W-1:0]         count_after,
    output logic signed [ppa_pkg::OWNER_W-1:0]    owner_after
);

    ppa_pkg::ppa_cmd_t cmd;
    ppa_pkg::ppa_sts_t sts;

    ppa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppa_dp
    #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_type        (req_type),
        .page_address    (page_address),
        .owner_id        (owner_id),
        .status          (status),
        .granted_address (granted_address),
        .count_after     (count_after),
        .owner_after     (owner_after)
    );

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request accepted while one is in progress");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !in_ready)
        else $error("request port open during clearing pass");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_next |-> !sts.chk_last)
        else $error("alloc scan stepped past last page");

    a_resp_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |=> out_valid)
        else $error("result loaded but not presented");

endmodule

/* hdl/ppa_ctrl.sv */
// Controller for the physical page allocator: clearing pass, request
// sequencing, alloc scan and the output valid. Depends on ppa_pkg.
module ppa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ppa_pkg::ppa_sts_t sts,
    output ppa_pkg::ppa_cmd_t cmd
);

    ppa_pkg::state_t state_reg;
    ppa_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ppa_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ppa_pkg::S_IDLE;
                end
            end
            ppa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ppa_pkg::S_LOOKUP;
                end
            end
            ppa_pkg::S_LOOKUP:
            begin
                if (sts.is_alloc)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ppa_pkg::S_SCAN;
                end
                else
                begin
                    cmd.rd_page = 1'b1;
                    state_next  = ppa_pkg::S_RESP;
                end
            end
            ppa_pkg::S_SCAN:
            begin
                if (sts.cnt_zero || sts.chk_last)
                begin
                    state_next = ppa_pkg::S_RESP;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            ppa_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = ppa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppa_pkg::S_CLEAR;
            end
        endcase
    end

    assign out_valid_next = cmd.resp_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppa_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ppa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hdl/ppa_dp.sv */
// Datapath for the physical page allocator: page table memory, request
// registers, result logic and output registers. Depends on ppa_pkg.
module ppa_dp
#(
    parameter int NUM_PAGES  = 512,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ppa_pkg::ppa_cmd_t                     cmd,
    output ppa_pkg::ppa_sts_t                     sts,
    input  logic [ppa_pkg::REQ_W-1:0]             req_type,
    input  logic [ppa_pkg::ADDR_W-1:0]            page_address,
    input  logic signed [ppa_pkg::OWNER_W-1:0]    owner_id,
    output logic [ppa_pkg::STATUS_W-1:0]          status,
    output logic [ppa_pkg::GRANT_W-1:0]           granted_address,
    output logic [ppa_pkg::CNT_OUT_W-1:0]         count_after,
    output logic signed [ppa_pkg::OWNER_W-1:0]    owner_after
);

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int ENTRY_W = COUNT_BITS + ppa_pkg::OWNER_W;
    localparam int CNT_EXT = (COUNT_BITS > ppa_pkg::CNT_OUT_W) ? COUNT_BITS
                                                               : ppa_pkg::CNT_OUT_W;
    localparam logic [ppa_pkg::ADDR_W-1:0] OFFSET_MASK =
        ppa_pkg::ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

    logic [ENTRY_W-1:0] page_mem [NUM_PAGES];

    logic [ppa_pkg::REQ_W-1:0]    req_type_reg;
    logic [ppa_pkg::ADDR_W-1:0]   req_addr_reg;
    logic [ppa_pkg::OWNER_W-1:0]  req_owner_reg;
    logic [PAGE_W-1:0]            clr_addr_reg;
    logic [PAGE_W-1:0]            rd_addr_reg;
    logic [ENTRY_W-1:0]           rdata_reg;
    logic [ppa_pkg::STATUS_W-1:0] status_reg;
    logic [ppa_pkg::GRANT_W-1:0]  grant_reg;
    logic [ppa_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic [ppa_pkg::OWNER_W-1:0]  own_out_reg;

    logic [ppa_pkg::ADDR_W-1:0]   page_full;
    logic [PAGE_W-1:0]            req_page;
    logic                         in_range;
    logic                         misaligned;
    logic [COUNT_BITS-1:0]        cur_cnt;
    logic [ppa_pkg::OWNER_W-1:0]  cur_own;
    logic                         rd_en;
    logic [PAGE_W-1:0]            rd_addr;
    logic                         wr_en;
    logic [PAGE_W-1:0]            wr_addr;
    logic [ENTRY_W-1:0]           wr_data;
    logic [ppa_pkg::ADDR_W-1:0]   grant_full;
    logic [CNT_EXT-1:0]           cnt_ext;

    logic [ppa_pkg::STATUS_W-1:0] res_status;
    logic                         res_grant;
    logic [COUNT_BITS-1:0]        res_cnt;
    logic [ppa_pkg::OWNER_W-1:0]  res_own;
    logic                         res_wr;

    assign page_full  = req_addr_reg >> PAGE_SHIFT;
    assign req_page   = page_full[PAGE_W-1:0];
    assign in_range   = page_full < ppa_pkg::ADDR_W'(NUM_PAGES);
    assign misaligned = (req_addr_reg & OFFSET_MASK) != '0;
    assign cur_cnt    = rdata_reg[COUNT_BITS-1:0];
    assign cur_own    = rdata_reg[ENTRY_W-1:COUNT_BITS];

    assign sts.clr_last = (clr_addr_reg == LAST_PAGE);
    assign sts.is_alloc = (req_type_reg == ppa_pkg::REQ_ALLOC);
    assign sts.cnt_zero = (cur_cnt == '0);
    assign sts.chk_last = (rd_addr_reg == LAST_PAGE);

    always_comb
    begin
        res_status = ppa_pkg::ST_OK;
        res_grant  = 1'b0;
        res_cnt    = '0;
        res_own    = '0;
        res_wr     = 1'b0;
        priority if (req_type_reg == ppa_pkg::REQ_ALLOC)
        begin
            if (cur_cnt == '0)
            begin
                res_grant = 1'b1;
                res_cnt   = COUNT_BITS'(1);
                res_own   = req_owner_reg;
                res_wr    = 1'b1;
            end
            else
            begin
                res_status = ppa_pkg::ST_NONE_FREE;
            end
        end
        else if (req_type_reg > ppa_pkg::REQ_QUERY)
        begin
            res_status = ppa_pkg::ST_OK;
        end
        else if (req_type_reg == ppa_pkg::REQ_ASSIGN && misaligned)
        begin
            res_status = ppa_pkg::ST_MISALIGNED;
        end
        else if (!in_range)
        begin
            res_status = ppa_pkg::ST_RANGE;
        end
        else if (req_type_reg == ppa_pkg::REQ_ASSIGN)
        begin
            if (cur_cnt != '0)
            begin
                res_status = ppa_pkg::ST_IN_USE;
                res_cnt    = cur_cnt;
                res_own    = cur_own;
            end
            else
            begin
                res_cnt = COUNT_BITS'(1);
                res_own = req_owner_reg;
                res_wr  = 1'b1;
            end
        end
        else if (req_type_reg == ppa_pkg::REQ_FREE)
        begin
            if (cur_cnt == '0)
            begin
                res_status = ppa_pkg::ST_NOT_HELD;
                res_own    = cur_own;
            end
            else
            begin
                res_cnt = cur_cnt - COUNT_BITS'(1);
                res_own = (res_cnt == '0) ? '0 : cur_own;
                res_wr  = 1'b1;
            end
        end
        else if (req_type_reg == ppa_pkg::REQ_SHARE)
        begin
            if (&cur_cnt)
            begin
                res_status = ppa_pkg::ST_SATURATED;
                res_cnt    = cur_cnt;
                res_own    = cur_own;
            end
            else
            begin
                res_cnt = cur_cnt + COUNT_BITS'(1);
                res_own = cur_own;
                res_wr  = 1'b1;
            end
        end
        else
        begin
            res_cnt = cur_cnt;
            res_own = cur_own;
        end
    end

    assign rd_en = cmd.rd_first || cmd.rd_page || cmd.rd_next;

    always_comb
    begin
        priority if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_addr = rd_addr_reg + PAGE_W'(1);
        end
        else
        begin
            rd_addr = req_page;
        end
    end

    assign wr_en   = cmd.clr_step || (cmd.resp_load && res_wr);
    assign wr_addr = cmd.clr_step ? clr_addr_reg : rd_addr_reg;
    assign wr_data = cmd.clr_step ? '0 : {res_own, res_cnt};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg   <= page_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + PAGE_W'(1);
        end
    end

    assign grant_full = res_grant ? (ppa_pkg::ADDR_W'(rd_addr_reg) << PAGE_SHIFT) : '0;
    assign cnt_ext    = CNT_EXT'(res_cnt);

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_type_reg  <= req_type;
            req_addr_reg  <= page_address;
            req_owner_reg <= owner_id;
        end
        if (cmd.resp_load)
        begin
            status_reg  <= res_status;
            grant_reg   <= grant_full[ppa_pkg::GRANT_W-1:0];
            cnt_out_reg <= cnt_ext[ppa_pkg::CNT_OUT_W-1:0];
            own_out_reg <= res_own;
        end
    end

    assign status          = status_reg;
    assign granted_address = grant_reg;
    assign count_after     = cnt_out_reg;
    assign owner_after     = own_out_reg;

endmodule
